// ----- sv/bpa_pkg.sv -----
package bpa_pkg;

  localparam int PAGE_W     = 16;
  localparam int LINK_W     = PAGE_W + 1;
  localparam int NUM_PAGES  = 1 << PAGE_W;
  localparam int NUM_ORDERS = 11;
  localparam int ORD_W      = 4;
  localparam int TOP_ORDER  = NUM_ORDERS - 1;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_PAGES);
  localparam logic [ORD_W-1:0]  TOP = ORD_W'(TOP_ORDER);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  localparam logic CFG_FIRST = 1'b0;
  localparam logic CFG_END   = 1'b1;

  typedef struct packed {
    logic [1:0]        op;
    logic [ORD_W-1:0]  order;
    logic [PAGE_W-1:0] page;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] block_page;
    logic [ORD_W-1:0]  block_order;
  } rsp_t;

  typedef struct packed {
    logic [PAGE_W-1:0] first;
    logic [LINK_W-1:0] endp;
  } cfg_t;

  typedef struct packed {
    logic              free_we;
    logic [PAGE_W-1:0] free_addr;
    logic              free_val;
    logic              ord_we;
    logic [PAGE_W-1:0] ord_addr;
    logic [ORD_W-1:0]  ord_val;
    logic              next_we;
    logic [PAGE_W-1:0] next_addr;
    logic [LINK_W-1:0] next_val;
    logic              prev_we;
    logic [PAGE_W-1:0] prev_addr;
    logic [LINK_W-1:0] prev_val;
  } mem_wr_t;

  typedef struct packed {
    logic              free;
    logic [ORD_W-1:0]  ord;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } mem_rd_t;

endpackage

// ----- sv/bpa_page_store.sv -----
module bpa_page_store (
  input  logic                      clk,
  input  bpa_pkg::mem_wr_t          wr,
  input  logic [bpa_pkg::PAGE_W-1:0] rd_addr,
  output bpa_pkg::mem_rd_t          rd
);
  import bpa_pkg::*;

  logic              free_mem [NUM_PAGES];
  logic [ORD_W-1:0]  ord_mem  [NUM_PAGES];
  logic [LINK_W-1:0] next_mem [NUM_PAGES];
  logic [LINK_W-1:0] prev_mem [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (wr.free_we) begin
      free_mem[wr.free_addr] <= wr.free_val;
    end
    if (wr.ord_we) begin
      ord_mem[wr.ord_addr] <= wr.ord_val;
    end
    if (wr.next_we) begin
      next_mem[wr.next_addr] <= wr.next_val;
    end
    if (wr.prev_we) begin
      prev_mem[wr.prev_addr] <= wr.prev_val;
    end
    rd.free <= free_mem[rd_addr];
    rd.ord  <= ord_mem[rd_addr];
    rd.next <= next_mem[rd_addr];
    rd.prev <= prev_mem[rd_addr];
  end

endmodule

// ----- sv/bpa_seq.sv -----
module bpa_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  bpa_pkg::req_t              req,
  input  bpa_pkg::cfg_t              cfg,
  output logic                       res_valid,
  input  logic                       res_ready,
  output bpa_pkg::rsp_t              res,
  output bpa_pkg::mem_wr_t           wr,
  output logic [bpa_pkg::PAGE_W-1:0] rd_addr,
  input  bpa_pkg::mem_rd_t           rd
);
  import bpa_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_SCAN, S_A_UL, S_A_SPLIT, S_A_FIN, S_F_CHK,
    S_M_CHK, S_M_RD, S_PUSH_A, S_PUSH_B, S_C_NEXT, S_C_FIT, S_DONE
  } state_t;

  state_t            state;
  logic [1:0]        op_r;
  logic [ORD_W-1:0]  want;
  logic [ORD_W-1:0]  k;
  logic [PAGE_W-1:0] p;
  logic [PAGE_W-1:0] q;
  logic [LINK_W-1:0] h;
  logic [LINK_W-1:0] a;
  logic [LINK_W-1:0] endc;
  logic [PAGE_W-1:0] clr;
  logic              init_pend;
  logic [LINK_W-1:0] head [NUM_ORDERS];

  logic [PAGE_W-1:0] bud;
  logic              do_ul;
  logic [PAGE_W-1:0] ul_page;
  logic [ORD_W-1:0]  ul_ord;
  logic [ORD_W-1:0]  rd_ord_c;
  logic [LINK_W-1:0] span;
  logic [LINK_W-1:0] blk;
  logic              carve_ok;
  logic              in_range;

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    bud      = p ^ (PAGE_W'(1) << k);
    rd_ord_c = (rd.ord > TOP) ? TOP : rd.ord;
    ul_ord   = rd_ord_c;
    do_ul    = (state == S_A_UL) ||
               ((state == S_M_RD) && rd.free && (rd.ord == k));
    ul_page  = (state == S_A_UL) ? p : bud;
    blk      = LINK_W'(1) << k;
    span     = endc - a;
    carve_ok = ((a & (blk - LINK_W'(1))) == '0) && (span >= blk);
    in_range = (bud >= cfg.first) && ({1'b0, bud} < cfg.endp);
    wr       = '0;
    rd_addr  = '0;
    case (state)
      S_IDLE:   rd_addr = req.page;
      S_A_SCAN: rd_addr = head[k][PAGE_W-1:0];
      S_M_CHK:  rd_addr = bud;
      S_CLR: begin
        wr.free_we   = 1'b1;
        wr.free_addr = clr;
        wr.free_val  = 1'b0;
      end
      S_PUSH_A: begin
        wr.next_we   = 1'b1;
        wr.next_addr = q;
        wr.next_val  = head[k];
        wr.prev_we   = 1'b1;
        wr.prev_addr = q;
        wr.prev_val  = NIL;
        wr.free_we   = 1'b1;
        wr.free_addr = q;
        wr.free_val  = 1'b1;
        wr.ord_we    = 1'b1;
        wr.ord_addr  = q;
        wr.ord_val   = k;
      end
      S_PUSH_B: begin
        wr.prev_we   = (h != NIL);
        wr.prev_addr = h[PAGE_W-1:0];
        wr.prev_val  = {1'b0, q};
      end
      S_A_FIN: begin
        wr.ord_we   = 1'b1;
        wr.ord_addr = p;
        wr.ord_val  = want;
      end
      default: ;
    endcase
    // unlink from the free list using the entry just read
    if (do_ul) begin
      wr.next_we   = (rd.prev != NIL);
      wr.next_addr = rd.prev[PAGE_W-1:0];
      wr.next_val  = rd.next;
      wr.prev_we   = (rd.next != NIL);
      wr.prev_addr = rd.next[PAGE_W-1:0];
      wr.prev_val  = rd.prev;
      wr.free_we   = 1'b1;
      wr.free_addr = ul_page;
      wr.free_val  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      init_pend <= 1'b0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        head[i] <= NIL;
      end
    end else begin
      if (do_ul && (rd.prev == NIL)) begin
        head[ul_ord] <= rd.next;
      end
      case (state)
        S_CLR: begin
          clr <= clr + PAGE_W'(1);
          if (clr == PAGE_W'(NUM_PAGES - 1)) begin
            if (init_pend) begin
              init_pend <= 1'b0;
              a         <= {1'b0, cfg.first};
              endc      <= (cfg.endp > NIL) ? NIL : cfg.endp;
              state     <= S_C_NEXT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op_r <= req.op;
            want <= req.order;
            k    <= req.order;
            p    <= req.page;
            res  <= '0;
            case (req.op)
              OP_ALLOC: state <= (req.order > TOP) ? S_DONE : S_A_SCAN;
              OP_FREE:  state <= S_F_CHK;
              OP_INIT: begin
                for (int i = 0; i < NUM_ORDERS; i++) begin
                  head[i] <= NIL;
                end
                clr       <= '0;
                init_pend <= 1'b1;
                state     <= S_CLR;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_A_SCAN: begin
          if (head[k] != NIL) begin
            p     <= head[k][PAGE_W-1:0];
            state <= S_A_UL;
          end else if (k == TOP) begin
            state <= S_DONE;
          end else begin
            k <= k + ORD_W'(1);
          end
        end
        S_A_UL: state <= S_A_SPLIT;
        S_A_SPLIT: begin
          if (k > want) begin
            k     <= k - ORD_W'(1);
            q     <= p ^ (PAGE_W'(1) << (k - ORD_W'(1)));
            state <= S_PUSH_A;
          end else begin
            state <= S_A_FIN;
          end
        end
        S_A_FIN: begin
          res.ok          <= 1'b1;
          res.block_page  <= p;
          res.block_order <= want;
          state           <= S_DONE;
        end
        S_F_CHK: begin
          if (rd.free) begin
            state <= S_DONE;
          end else begin
            k     <= rd_ord_c;
            state <= S_M_CHK;
          end
        end
        S_M_CHK: begin
          if ((k == TOP) || !in_range) begin
            q     <= p;
            state <= S_PUSH_A;
          end else begin
            state <= S_M_RD;
          end
        end
        S_M_RD: begin
          if (do_ul) begin
            p     <= p & ~(PAGE_W'(1) << k);
            k     <= k + ORD_W'(1);
            state <= S_M_CHK;
          end else begin
            q     <= p;
            state <= S_PUSH_A;
          end
        end
        S_PUSH_A: begin
          h       <= head[k];
          head[k] <= {1'b0, q};
          state   <= S_PUSH_B;
        end
        S_PUSH_B: begin
          case (op_r)
            OP_ALLOC: state <= S_A_SPLIT;
            OP_FREE: begin
              res.ok          <= 1'b1;
              res.block_page  <= q;
              res.block_order <= k;
              state           <= S_DONE;
            end
            default: begin
              a     <= a + blk;
              state <= S_C_NEXT;
            end
          endcase
        end
        S_C_NEXT: begin
          if (a < endc) begin
            k     <= TOP;
            state <= S_C_FIT;
          end else begin
            res.ok <= 1'b1;
            state  <= S_DONE;
          end
        end
        S_C_FIT: begin
          if (carve_ok || (k == '0)) begin
            q     <= a[PAGE_W-1:0];
            state <= S_PUSH_A;
          end else begin
            k <= k - ORD_W'(1);
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/buddy_page_allocator_top.sv -----
// buddy page allocator over page indices
// request channel: req_valid/req_stall carry req (op, order, page);
// op allocate takes a block of 2^order pages, free returns a block and
// merges it with free buddies, init clears all lists and carves the region
// set by the two config registers into aligned blocks
// response channel: rsp_valid/rsp_stall carry rsp (ok, block_page,
// block_order), exactly one response per request, held while stalled
// config: cfg_we writes cfg_data into register cfg_index (0 first page,
// 1 end page); the user must write only while the block is idle, which
// the block does not enforce; one request at a time; the sequencer
// does one list step per cycle: allocate scans the orders upward and
// splits the block it finds; free merges with free buddies of its order
// until the top order or a buddy outside the range ends it; a free of
// an already free page is refused; init runs a pass clearing the free
// flags, then carves the region into aligned blocks; after reset the
// same pass runs with req_stall high
// a response waits in the output register while rsp_stall is high; the
// next request is taken meanwhile
module buddy_page_allocator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  bpa_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output bpa_pkg::rsp_t              rsp,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bpa_pkg::LINK_W-1:0] cfg_data
);
  import bpa_pkg::*;

  cfg_t              cfg;
  rsp_t              res;
  logic              res_valid;
  logic              res_ready;
  mem_wr_t           wr;
  logic [PAGE_W-1:0] rd_addr;
  mem_rd_t           rd;

  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first <= PAGE_W'(1);
      cfg.endp  <= NIL;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST: cfg.first <= cfg_data[PAGE_W-1:0];
          CFG_END:   cfg.endp  <= cfg_data;
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  bpa_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd        (rd)
  );

  bpa_page_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

endmodule
